// ----- sv/alist_pkg.sv -----
`timescale 1ns / 1ps

package alist_pkg;

  localparam logic [1:0] MODE_READ   = 2'd0;
  localparam logic [1:0] MODE_INSERT = 2'd1;
  localparam logic [1:0] MODE_DELETE = 2'd2;
  localparam logic [1:0] MODE_CLEAR  = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_END  = 2'd2;

  localparam int IN_BYTES  = 3;
  localparam int OUT_BYTES = 2;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_WAIT  = 9'b000000010,
    S_LOOK  = 9'b000000100,
    S_DWAIT = 9'b000001000,
    S_DLINK = 9'b000010000,
    S_SCAN  = 9'b000100000,
    S_INS   = 9'b001000000,
    S_INS2  = 9'b010000000,
    S_RESP  = 9'b100000000
  } state_t;

endpackage

// ----- sv/array_linked_list.sv -----
`timescale 1ns / 1ps
// A clear or a bad start cell gives its result the cycle after the item is taken.
// A read walks the links from the start cell towards position, one cell per S_WAIT/S_LOOK
// pair; a delete adds S_DWAIT and S_DLINK, and an insert adds the free-cell scan (S_SCAN,
// one cell checked at a time, up to CELLS) and the writes in S_INS and S_INS2. One item is
// in flight at a time; the next item is taken the cycle after the result is taken.
// Reset (rst, synchronous, active high) empties the list and frees every cell.
module array_linked_list #(
  parameter int CELLS = 15
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // Fields from bit 0 up: mode[1:0], start_cell[5:2], position[9:6], write_value[17:10].
  input  logic [alist_pkg::IN_BYTES*8-1:0]    s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // Fields from bit 0 up: read_value[7:0], cell_used[11:8], status[13:12], list_empty[14].
  output logic [alist_pkg::OUT_BYTES*8-1:0]   m_axis_tdata
);
  import alist_pkg::*;

  localparam int IDXW = $clog2(CELLS + 1);

  state_t            state;
  logic [1:0]        mode;
  logic [7:0]        wval;
  logic [3:0]        steps;
  logic [IDXW-1:0]   cur;
  logic [IDXW-1:0]   prev;
  logic [IDXW-1:0]   idx;
  logic [IDXW-1:0]   aux;
  logic [IDXW-1:0]   used;
  logic [IDXW-1:0]   head_link;
  logic [7:0]        rv;
  logic [1:0]        status;
  logic [CELLS:0]    in_use;

  logic [7:0]        value_mem [CELLS+1];
  logic [IDXW-1:0]   link_mem  [CELLS+1];
  logic [7:0]        value_q;
  logic [IDXW-1:0]   link_q;

  logic              link_we;
  logic              value_we;
  logic [IDXW-1:0]   waddr;
  logic [IDXW-1:0]   link_wdata;

  logic [1:0]        in_mode;
  logic [3:0]        in_start;
  logic [3:0]        in_pos;
  logic [7:0]        in_wval;
  logic              bad_start;
  logic [IDXW-1:0]   cur_link;

  assign in_mode  = s_axis_tdata[1:0];
  assign in_start = s_axis_tdata[5:2];
  assign in_pos   = s_axis_tdata[9:6];
  assign in_wval  = s_axis_tdata[17:10];

  assign bad_start = (int'(in_start) > CELLS) ||
                     ((in_start != 4'd0) && !in_use[IDXW'(in_start)]);

  assign cur_link = (cur == '0) ? head_link : link_q;

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = (state == S_RESP);
  assign m_axis_tdata  = {1'b0, (head_link == '0), status, 4'(used), rv};

  always_ff @(posedge clk) begin
    value_q <= value_mem[cur];
    link_q  <= link_mem[cur];
    if (value_we) begin
      value_mem[waddr] <= wval;
    end
    if (link_we) begin
      link_mem[waddr] <= link_wdata;
    end
  end

  always_comb begin
    link_we    = 1'b0;
    value_we   = 1'b0;
    waddr      = cur;
    link_wdata = aux;
    unique case (state)
      S_INS: begin
        link_we  = 1'b1;
        value_we = 1'b1;
        waddr    = idx;
      end
      S_INS2: begin
        link_we    = (cur != '0);
        link_wdata = idx;
      end
      S_DLINK: begin
        link_we    = (prev != '0);
        waddr      = prev;
        link_wdata = link_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head_link <= '0;
      in_use    <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            mode   <= in_mode;
            wval   <= in_wval;
            rv     <= 8'd0;
            used   <= '0;
            status <= ST_OK;
            cur    <= IDXW'(in_start);
            steps  <= (in_pos > 4'd1) ? in_pos - 4'd1 : 4'd0;
            if (in_mode == MODE_CLEAR) begin
              head_link <= '0;
              in_use    <= '0;
              state     <= S_RESP;
            end else if (bad_start) begin
              status <= ST_END;
              state  <= S_RESP;
            end else begin
              state <= S_WAIT;
            end
          end
        end
        S_WAIT: begin
          state <= S_LOOK;
        end
        S_LOOK: begin
          if (steps != 4'd0) begin
            if (cur_link == '0) begin
              status <= ST_END;
              state  <= S_RESP;
            end else begin
              cur   <= cur_link;
              steps <= steps - 4'd1;
              state <= S_WAIT;
            end
          end else begin
            unique case (mode)
              MODE_READ: begin
                rv    <= (cur != '0) ? value_q : 8'd0;
                used  <= cur;
                state <= S_RESP;
              end
              MODE_INSERT: begin
                aux   <= cur_link;
                idx   <= IDXW'(1);
                state <= S_SCAN;
              end
              default: begin
                if (cur_link == '0) begin
                  status <= ST_END;
                  state  <= S_RESP;
                end else begin
                  prev  <= cur;
                  cur   <= cur_link;
                  state <= S_DWAIT;
                end
              end
            endcase
          end
        end
        S_DWAIT: begin
          state <= S_DLINK;
        end
        S_DLINK: begin
          if (prev == '0) begin
            head_link <= link_q;
          end
          in_use[cur] <= 1'b0;
          used        <= cur;
          state       <= S_RESP;
        end
        S_SCAN: begin
          if (!in_use[idx]) begin
            state <= S_INS;
          end else if (int'(idx) == CELLS) begin
            status <= ST_FULL;
            state  <= S_RESP;
          end else begin
            idx <= idx + IDXW'(1);
          end
        end
        S_INS: begin
          in_use[idx] <= 1'b1;
          state       <= S_INS2;
        end
        S_INS2: begin
          if (cur == '0) begin
            head_link <= idx;
          end
          used  <= idx;
          state <= S_RESP;
        end
        S_RESP: begin
          if (m_axis_tready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- sv/alist_checker.sv -----
`timescale 1ns / 1ps

module alist_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               s_axis_tvalid,
  input logic                               s_axis_tready,
  input logic [alist_pkg::IN_BYTES*8-1:0]   s_axis_tdata,
  input logic                               m_axis_tvalid,
  input logic                               m_axis_tready,
  input logic [alist_pkg::OUT_BYTES*8-1:0]  m_axis_tdata
);
  import alist_pkg::*;

  logic [7:0] o_rv;
  logic [3:0] o_used;
  logic [1:0] o_status;
  logic       in_take;

  assign o_rv     = m_axis_tdata[7:0];
  assign o_used   = m_axis_tdata[11:8];
  assign o_status = m_axis_tdata[13:12];
  assign in_take  = s_axis_tvalid && s_axis_tready && (s_axis_tdata[1:0] == MODE_CLEAR);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("Result item changed while stalled.");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("Input taken while a result item is pending.");

  a_fail_fields: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (o_status == ST_FULL || o_status == ST_END)
      |-> o_rv == 8'd0 && o_used == 4'd0)
    else $error("Failed operation reported a value or a cell.");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> o_status != 2'd3)
    else $error("Undefined status code.");

  a_clear_empty: assert property (@(posedge clk) disable iff (rst)
    in_take |=> m_axis_tvalid && m_axis_tdata[14] && o_status == ST_OK)
    else $error("Clear did not leave an empty list.");

endmodule

bind array_linked_list alist_checker u_alist_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
